[hdl/assert_macros.svh]
// assertion macros shared by the access unit grouper rtl
// no dependencies; clock and active-low reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: property failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

[hdl/tsaug_pkg.sv]
// types and constants of the transport stream access unit grouper
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tsaug_pkg;

  localparam int OFFSET_BITS = 40;
  localparam int COUNT_BITS  = 16;
  localparam int PID_BITS    = 13;
  localparam int UNIT_BITS   = 24;
  localparam int CFG_BITS    = 13;
  localparam int IDX_BITS    = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [PID_BITS-1:0]   PID_ALL   = '1;

  // register indexes of the configuration port
  localparam logic [IDX_BITS-1:0] CFG_VIDEO_PID    = 2'd0;
  localparam logic [IDX_BITS-1:0] CFG_AUDIO_PID    = 2'd1;
  localparam logic [IDX_BITS-1:0] CFG_VIDEO_ENABLE = 2'd2;
  localparam logic [IDX_BITS-1:0] CFG_AUDIO_ENABLE = 2'd3;

  // stream codes
  localparam logic STREAM_VIDEO = 1'b0;
  localparam logic STREAM_AUDIO = 1'b1;

  // item modes
  localparam logic MODE_PACKET = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  typedef struct packed {
    logic [PID_BITS-1:0] video_pid;
    logic [PID_BITS-1:0] audio_pid;
    logic                video_enable;
    logic                audio_enable;
  } tsaug_cfg_t;

  typedef struct packed {
    logic                   stream_id;
    logic [OFFSET_BITS-1:0] run_start_byte;
    logic [COUNT_BITS-1:0]  run_packets;
    logic [UNIT_BITS-1:0]   unit_number;
    logic                   end_of_unit;
    logic                   last_record;
  } tsaug_rec_t;

  // up to two result beats per item; second only with the first
  typedef struct packed {
    logic       push0;
    logic       push1;
    tsaug_rec_t rec0;
    tsaug_rec_t rec1;
  } tsaug_push_t;

endpackage

[hdl/tsaug_engine.sv]
// input register, run state and per-item update of the access unit grouper
// depends on tsaug_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsaug_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tsaug_pkg::tsaug_cfg_t           cfg_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [tsaug_pkg::PID_BITS-1:0]  pid_i,
  input  logic                            unit_start_i,
  input  logic [tsaug_pkg::OFFSET_BITS-1:0] byte_offset_i,
  input  logic                            space_ok_i,
  output tsaug_pkg::tsaug_push_t          push_o
);
  import tsaug_pkg::*;

  // input register
  logic                   item_vld_q, item_vld_d;
  logic                   mode_q;
  logic [PID_BITS-1:0]    pid_q;
  logic                   us_q;
  logic [OFFSET_BITS-1:0] off_q;

  // run state
  logic [PID_BITS-1:0]    last_pid_q, last_pid_d;
  logic                   last_vld_q, last_vld_d;
  logic [1:0]             open_q, open_d;
  logic [OFFSET_BITS-1:0] start_q [2];
  logic [OFFSET_BITS-1:0] start_d [2];
  logic [COUNT_BITS-1:0]  count_q [2];
  logic [COUNT_BITS-1:0]  count_d [2];
  logic [UNIT_BITS-1:0]   unit_q  [2];
  logic [UNIT_BITS-1:0]   unit_d  [2];

  logic accept;
  logic item_go;
  logic match_v;
  logic match_a;
  logic matched;
  logic sel;
  logic fresh;

  tsaug_rec_t rec_v;
  tsaug_rec_t rec_a;
  tsaug_rec_t rec_s;

  assign item_go    = item_vld_q && space_ok_i;
  assign in_stall_o = item_vld_q && !space_ok_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    item_vld_d = item_vld_q;
    if (accept) begin
      item_vld_d = 1'b1;
    end else if (item_go) begin
      item_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      pid_q  <= pid_i;
      us_q   <= unit_start_i;
      off_q  <= byte_offset_i;
    end
  end

  // stream match, video wins when both pids match
  assign match_v = cfg_i.video_enable && (pid_q == cfg_i.video_pid);
  assign match_a = cfg_i.audio_enable && (pid_q == cfg_i.audio_pid) && !match_v;
  assign matched = match_v || match_a;
  assign sel     = match_v ? STREAM_VIDEO : STREAM_AUDIO;
  assign fresh   = us_q || !open_q[sel] || (last_vld_q && (pid_q != last_pid_q));

  always_comb begin
    rec_v.stream_id      = STREAM_VIDEO;
    rec_v.run_start_byte = start_q[0];
    rec_v.run_packets    = count_q[0];
    rec_v.unit_number    = unit_q[0];
    rec_v.end_of_unit    = 1'b1;
    rec_v.last_record    = 1'b1;
    rec_a.stream_id      = STREAM_AUDIO;
    rec_a.run_start_byte = start_q[1];
    rec_a.run_packets    = count_q[1];
    rec_a.unit_number    = unit_q[1];
    rec_a.end_of_unit    = 1'b1;
    rec_a.last_record    = 1'b1;
    rec_s                = sel ? rec_a : rec_v;
    rec_s.end_of_unit    = us_q;
  end

  // result beats
  always_comb begin
    push_o.push0 = 1'b0;
    push_o.push1 = 1'b0;
    push_o.rec0  = rec_s;
    push_o.rec1  = rec_a;
    if (item_go) begin
      if (mode_q == MODE_FLUSH) begin
        push_o.push0 = open_q[0] || open_q[1];
        push_o.push1 = open_q[0] && open_q[1];
        push_o.rec0  = open_q[0] ? rec_v : rec_a;
        push_o.rec0.last_record = !(open_q[0] && open_q[1]);
      end else begin
        push_o.push0 = matched && fresh && open_q[sel];
      end
    end
  end

  // state update
  always_comb begin
    last_pid_d = last_pid_q;
    last_vld_d = last_vld_q;
    open_d     = open_q;
    start_d    = start_q;
    count_d    = count_q;
    unit_d     = unit_q;
    if (item_go) begin
      if (mode_q == MODE_FLUSH) begin
        for (int s = 0; s < 2; s++) begin
          if (open_q[s]) begin
            unit_d[s]  = unit_q[s] + UNIT_BITS'(1);
            open_d[s]  = 1'b0;
            start_d[s] = '0;
            count_d[s] = '0;
          end
        end
        last_vld_d = 1'b0;
      end else if (matched) begin
        if (fresh) begin
          if (open_q[sel] && us_q) begin
            unit_d[sel] = unit_q[sel] + UNIT_BITS'(1);
          end
          open_d[sel]  = 1'b1;
          start_d[sel] = off_q;
          count_d[sel] = COUNT_BITS'(1);
        end else if (count_q[sel] != COUNT_MAX) begin
          count_d[sel] = count_q[sel] + COUNT_BITS'(1);
        end
        last_pid_d = pid_q;
        last_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pid_q <= '0;
      last_vld_q <= 1'b0;
      open_q     <= '0;
      start_q    <= '{default: '0};
      count_q    <= '{default: '0};
      unit_q     <= '{default: '0};
    end else begin
      last_pid_q <= last_pid_d;
      last_vld_q <= last_vld_d;
      open_q     <= open_d;
      start_q    <= start_d;
      count_q    <= count_d;
      unit_q     <= unit_d;
    end
  end

  // a flush leaves no open run
  `ASSERT_AT(a_flush_closes, clk_i, rst_ni,
             (item_go && (mode_q == MODE_FLUSH)) |=> (open_q == 2'b00))
  // a packet closes at most one run
  `ASSERT_NEVER(a_packet_one_beat, clk_i, rst_ni,
                item_go && (mode_q == MODE_PACKET) && push_o.push1)
  // an open run always holds at least one packet
  `ASSERT_NEVER(a_open_nonempty, clk_i, rst_ni,
                (open_q[0] && (count_q[0] == '0)) || (open_q[1] && (count_q[1] == '0)))

endmodule

[hdl/tsaug_outq.sv]
// four-entry result queue taking up to two beats per cycle, one out when not stalled
// depends on tsaug_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tsaug_outq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tsaug_pkg::tsaug_push_t push_i,
  output logic                   space_ok_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output tsaug_pkg::tsaug_rec_t  rec_o
);
  import tsaug_pkg::*;

  localparam int DEPTH    = 4;
  localparam int PTR_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = PTR_BITS + 1;

  tsaug_rec_t          mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign rec_o       = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign space_ok_o  = (cnt_q <= CNT_BITS'(DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_BITS'(push_i.push0) + PTR_BITS'(push_i.push1);
    rd_ptr_d = rd_ptr_q + PTR_BITS'(pop);
    cnt_d    = cnt_q + CNT_BITS'(push_i.push0) + CNT_BITS'(push_i.push1)
               - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_ptr_q] <= push_i.rec0;
    end
    if (push_i.push1) begin
      mem_q[wr_ptr_q + PTR_BITS'(1)] <= push_i.rec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // beats arrive only with room for two
  `ASSERT_AT(a_push_room, clk_i, rst_ni, push_i.push0 |-> space_ok_o)
  // second beat never alone
  `ASSERT_AT(a_push_order, clk_i, rst_ni, push_i.push1 |-> push_i.push0)
  // pointers and fill level agree
  `ASSERT_AT(a_ptr_count, clk_i, rst_ni,
             (cnt_q == '0 || cnt_q == CNT_BITS'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))

endmodule

[hdl/ts_access_unit_grouper_core.sv]
// Transport stream access unit grouper, top level.
// Channels: the input channel carries one beat per packet header (mode, pid,
// unit_start, byte_offset) or a flush beat (mode = 1). The output channel
// carries one closed run per beat; last_record marks the final beat caused
// by an input beat. Both use valid/stall; a beat moves when valid is high
// and stall is low.
// Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 video pid,
// 1 audio pid, 2 video enable, 3 audio enable); write only while idle.
// Path: an input beat is taken into the input register; its results then go
// into the result queue, from which the output channel reads them.
// Throughput: one input beat per cycle unless stalled; a flush with two open
// runs gives two output beats; the queue drains one per cycle if unstalled.
// Stall: the four-entry result queue absorbs output stalls; once fewer than
// two entries are free the input register holds its beat and raises stall.
// Reset: clears run state, unit counters and the queue; pids go to 8191 and
// both streams are disabled.
// Depends on tsaug_pkg, tsaug_engine and tsaug_outq.
`timescale 1ns / 1ps

module ts_access_unit_grouper_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsaug_pkg::IDX_BITS-1:0]    cfg_idx_i,
  input  logic [tsaug_pkg::CFG_BITS-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [tsaug_pkg::PID_BITS-1:0]    pid_i,
  input  logic                              unit_start_i,
  input  logic [tsaug_pkg::OFFSET_BITS-1:0] byte_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              stream_id_o,
  output logic [tsaug_pkg::OFFSET_BITS-1:0] run_start_byte_o,
  output logic [tsaug_pkg::COUNT_BITS-1:0]  run_packets_o,
  output logic [tsaug_pkg::UNIT_BITS-1:0]   unit_number_o,
  output logic                              end_of_unit_o,
  output logic                              last_record_o
);
  import tsaug_pkg::*;

  tsaug_cfg_t  cfg_q, cfg_d;
  tsaug_push_t push;
  tsaug_rec_t  rec;
  logic        space_ok;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIDEO_PID:    cfg_d.video_pid    = cfg_data_i[PID_BITS-1:0];
        CFG_AUDIO_PID:    cfg_d.audio_pid    = cfg_data_i[PID_BITS-1:0];
        CFG_VIDEO_ENABLE: cfg_d.video_enable = cfg_data_i[0];
        CFG_AUDIO_ENABLE: cfg_d.audio_enable = cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.video_pid    <= PID_ALL;
      cfg_q.audio_pid    <= PID_ALL;
      cfg_q.video_enable <= 1'b0;
      cfg_q.audio_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsaug_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .pid_i         (pid_i),
    .unit_start_i  (unit_start_i),
    .byte_offset_i (byte_offset_i),
    .space_ok_i    (space_ok),
    .push_o        (push)
  );

  tsaug_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_ok_o  (space_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .rec_o       (rec)
  );

  assign stream_id_o      = rec.stream_id;
  assign run_start_byte_o = rec.run_start_byte;
  assign run_packets_o    = rec.run_packets;
  assign unit_number_o    = rec.unit_number;
  assign end_of_unit_o    = rec.end_of_unit;
  assign last_record_o    = rec.last_record;

endmodule
